>>> rtl/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types, character codes and helpers of the csv field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

  typedef enum logic [2:0] {
    SP_BEGIN,
    SP_NORMAL,
    SP_QUOTED,
    SP_QQUOTE,
    SP_NESC,
    SP_QESC
  } split_state_t;

  typedef enum logic [2:0] {
    UQ_NORMAL,
    UQ_NESC,
    UQ_QUOTED,
    UQ_QESC,
    UQ_QQUOTE
  } uq_state_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DRAIN,
    SQ_CHAR,
    SQ_FLUSH,
    SQ_END,
    SQ_EOS
  } seq_state_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_CHAR       = 2'd0;
  localparam kind_t KIND_FIELD_END  = 2'd1;
  localparam kind_t KIND_RECORD_END = 2'd2;
  localparam kind_t KIND_NO_MORE    = 2'd3;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_T         = 8'h74;

  localparam logic [6:0] DELIM_RESET  = 7'h2C;

  // result of one pass through the unquote unit
  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    uq_state_t  next;
  } uq_res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
  endfunction

endpackage

>>> rtl/cft_hold_buf.sv
// ----------------------------------------------------------------------------
// cft_hold_buf
// Hold buffer for inner whitespace: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cft_hold_buf #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/cft_unquote.sv
// ----------------------------------------------------------------------------
// cft_unquote
// Unquote unit: resolves quotes, escapes and CR for one field byte.
// ----------------------------------------------------------------------------
module cft_unquote import cft_pkg::*; (
  input  uq_state_t  state,
  input  logic [7:0] c,
  output uq_res_t    res
);

  logic [7:0] esc_ch;

  assign esc_ch = (c == CH_N) ? CH_LF : ((c == CH_T) ? CH_TAB : c);

  always_comb begin
    res.emit = 1'b0;
    res.ch   = c;
    res.next = state;
    case (state)
      UQ_NESC: begin
        res.emit = 1'b1;
        res.ch   = esc_ch;
        res.next = UQ_NORMAL;
      end
      UQ_QUOTED: begin
        if (c == CH_BACKSLASH) begin
          res.next = UQ_QESC;
        end else if (c == CH_QUOTE) begin
          res.next = UQ_QQUOTE;
        end else if (c != CH_CR) begin
          res.emit = 1'b1;
        end
      end
      UQ_QESC: begin
        res.emit = 1'b1;
        res.ch   = esc_ch;
        res.next = UQ_QUOTED;
      end
      UQ_QQUOTE: begin
        if (c == CH_QUOTE) begin
          res.emit = 1'b1;
          res.next = UQ_QUOTED;
        end else if (c == CH_CR) begin
          res.next = UQ_QUOTED;
        end else begin
          res.emit = 1'b1;
          res.next = UQ_NORMAL;
        end
      end
      default: begin
        if (c == CH_BACKSLASH) begin
          res.next = UQ_NESC;
        end else if (c == CH_QUOTE) begin
          res.next = UQ_QUOTED;
        end else if (c != CH_CR) begin
          res.emit = 1'b1;
        end
      end
    endcase
  end

endmodule

>>> rtl/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Streaming CSV splitter and field unquoter with whitespace stripping.
// ----------------------------------------------------------------------------
// Input beats carry one text byte on s_axis_tdata, or an end-of-input mark
// on s_axis_tuser. Output beats carry resolved characters and field, record
// and end-of-stream marks; m_axis_tlast flags the final beat an input beat
// causes. The user must write the delimiter through cfg_we / cfg_data while
// idle; the block does not enforce this. One sequencer drives a single
// shared unquote unit over the held whitespace and then the new byte, one
// byte per cycle once the output is free; the hold buffer read port sets
// this drain rate. Non-whitespace text bytes run through the drain state if
// spaces are held, then the char and flush states, whether or not they
// yield a character; a field end runs through the end state, then
// end-of-stream if end of input follows; end of input at record begin goes
// to end-of-stream. s_axis_tready is high only while the sequencer is idle.
// Results sit in an output register; when the receiver stalls the sequencer
// waits and no beat is lost. Reset clears the state machines and valid
// flags, sets the delimiter to a comma; the hold buffer needs no clearing.
// ----------------------------------------------------------------------------
module csv_field_tokenizer import cft_pkg::*; #(
  parameter int HOLD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tuser,   // [0] end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic [2:0] m_axis_tuser,   // [1:0] kind, [2] space_overflow
  output logic       m_axis_tlast,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data
);

  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  logic [6:0]   delimiter;
  split_state_t split_state;
  uq_state_t    unquote_state;
  seq_state_t   seq, seq_next;
  logic         seen_nonspace;
  logic [CW-1:0] held_count;
  logic         field_overflow;
  logic [CW-1:0] idx, idx_next;
  logic [7:0]   cbyte;
  kind_t        end_kind;
  logic         eoi_flag;
  logic         pend_v;
  logic [7:0]   pend_ch;
  logic         obuf_v;
  logic [7:0]   obuf_ch;
  kind_t        obuf_kind;
  logic         obuf_last;
  logic         obuf_ovf;

  logic         accept, out_free, step_uq;
  logic         in_eoi, in_space, do_end;
  kind_t        do_kind;
  split_state_t split_next;
  logic         load_o;
  logic [7:0]   o_ch;
  kind_t        o_kind;
  logic         o_last, o_ovf;
  logic         wr_en, rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]   rd_data;
  logic [7:0]   uq_in;
  uq_res_t      uq_res;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !obuf_v || m_axis_tready;
  assign step_uq  = ((seq == SQ_DRAIN) || (seq == SQ_CHAR)) && out_free;
  assign in_eoi   = s_axis_tuser;
  assign in_space = is_space(s_axis_tdata);
  assign idx_next = idx + CW'(1);
  assign uq_in    = (seq == SQ_DRAIN) ? rd_data : cbyte;

  assign s_axis_tready = (seq == SQ_IDLE);
  assign m_axis_tvalid = obuf_v;
  assign m_axis_tdata  = obuf_ch;
  assign m_axis_tuser  = {obuf_ovf, obuf_kind};
  assign m_axis_tlast  = obuf_last;

  // splitter decision for a byte beat; delimiter test wins where checked
  always_comb begin
    do_end     = 1'b0;
    do_kind    = KIND_FIELD_END;
    split_next = split_state;
    case (split_state)
      SP_QUOTED: begin
        if (s_axis_tdata == CH_QUOTE) begin
          split_next = SP_QQUOTE;
        end else if (s_axis_tdata == CH_BACKSLASH) begin
          split_next = SP_QESC;
        end
      end
      SP_QQUOTE: begin
        if (s_axis_tdata == {1'b0, delimiter}) begin
          do_end     = 1'b1;
          split_next = SP_NORMAL;
        end else if (s_axis_tdata == CH_QUOTE) begin
          split_next = SP_QUOTED;
        end else if (s_axis_tdata == CH_LF) begin
          do_end     = 1'b1;
          do_kind    = KIND_RECORD_END;
          split_next = SP_BEGIN;
        end else begin
          split_next = SP_NORMAL;
        end
      end
      SP_NESC: split_next = SP_NORMAL;
      SP_QESC: split_next = SP_QUOTED;
      default: begin
        if (s_axis_tdata == {1'b0, delimiter}) begin
          do_end     = 1'b1;
          split_next = SP_NORMAL;
        end else if (s_axis_tdata == CH_QUOTE) begin
          split_next = SP_QUOTED;
        end else if (s_axis_tdata == CH_BACKSLASH) begin
          split_next = SP_NESC;
        end else if (s_axis_tdata == CH_LF) begin
          do_end     = 1'b1;
          do_kind    = KIND_RECORD_END;
          split_next = SP_BEGIN;
        end else begin
          split_next = SP_NORMAL;
        end
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    seq_next = seq;
    case (seq)
      SQ_IDLE: begin
        if (accept) begin
          if (in_eoi) begin
            seq_next = (split_state != SP_BEGIN) ? SQ_END : SQ_EOS;
          end else if (do_end) begin
            seq_next = SQ_END;
          end else if (!in_space) begin
            seq_next = (held_count != '0) ? SQ_DRAIN : SQ_CHAR;
          end
        end
      end
      SQ_DRAIN: if (step_uq && (idx_next == held_count)) seq_next = SQ_CHAR;
      SQ_CHAR:  if (step_uq) seq_next = SQ_FLUSH;
      SQ_FLUSH: if (!pend_v || out_free) seq_next = SQ_IDLE;
      SQ_END:   if (out_free) seq_next = eoi_flag ? SQ_EOS : SQ_IDLE;
      SQ_EOS:   if (out_free) seq_next = SQ_IDLE;
      default:  seq_next = SQ_IDLE;
    endcase
  end

  // sequencer outputs: output register load and hold buffer ports
  always_comb begin
    load_o = 1'b0;
    o_ch   = 8'd0;
    o_kind = KIND_CHAR;
    o_last = 1'b0;
    o_ovf  = 1'b0;
    case (seq)
      SQ_DRAIN, SQ_CHAR: begin
        // a new character pushes the pending one out, not yet last
        if (step_uq && uq_res.emit && pend_v) begin
          load_o = 1'b1;
          o_ch   = pend_ch;
        end
      end
      SQ_FLUSH: begin
        if (pend_v && out_free) begin
          load_o = 1'b1;
          o_ch   = pend_ch;
          o_last = 1'b1;
        end
      end
      SQ_END: begin
        if (out_free) begin
          load_o = 1'b1;
          o_kind = end_kind;
          o_ovf  = field_overflow;
          o_last = !eoi_flag;
        end
      end
      SQ_EOS: begin
        if (out_free) begin
          load_o = 1'b1;
          o_kind = KIND_NO_MORE;
          o_last = 1'b1;
        end
      end
      default: load_o = 1'b0;
    endcase
  end

  assign wr_en = accept && !in_eoi && !do_end && in_space && seen_nonspace &&
                 (held_count < CW'(HOLD_DEPTH));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (accept) begin
      rd_en = 1'b1;
    end else if ((seq == SQ_DRAIN) && step_uq && (idx_next != held_count)) begin
      rd_en   = 1'b1;
      rd_addr = idx_next[AW-1:0];
    end
  end

  cft_hold_buf #(
    .DEPTH (HOLD_DEPTH),
    .AW    (AW)
  ) u_hold (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (held_count[AW-1:0]),
    .wr_data (s_axis_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cft_unquote u_unquote (
    .state (unquote_state),
    .c     (uq_in),
    .res   (uq_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= SQ_IDLE;
      delimiter      <= DELIM_RESET;
      split_state    <= SP_BEGIN;
      unquote_state  <= UQ_NORMAL;
      seen_nonspace  <= 1'b0;
      held_count     <= '0;
      field_overflow <= 1'b0;
      pend_v         <= 1'b0;
      obuf_v         <= 1'b0;
    end else begin
      seq <= seq_next;
      if (cfg_we) begin
        delimiter <= cfg_data;
      end
      if (accept) begin
        if (in_eoi) begin
          split_state <= SP_BEGIN;
        end else begin
          split_state <= split_next;
          if (!do_end) begin
            if (!in_space) begin
              seen_nonspace <= 1'b1;
            end else if (seen_nonspace && !(held_count < CW'(HOLD_DEPTH))) begin
              field_overflow <= 1'b1;
            end else if (wr_en) begin
              held_count <= held_count + CW'(1);
            end
          end
        end
      end
      if (step_uq) begin
        unquote_state <= uq_res.next;
        if (uq_res.emit) begin
          pend_v <= 1'b1;
        end
        if (seq == SQ_CHAR) begin
          held_count <= '0;
        end
      end
      if ((seq == SQ_FLUSH) && out_free) begin
        pend_v <= 1'b0;
      end
      if ((seq == SQ_END) && out_free) begin
        unquote_state  <= UQ_NORMAL;
        seen_nonspace  <= 1'b0;
        held_count     <= '0;
        field_overflow <= 1'b0;
      end
      if (load_o) begin
        obuf_v <= 1'b1;
      end else if (m_axis_tready) begin
        obuf_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cbyte    <= s_axis_tdata;
      eoi_flag <= in_eoi;
      end_kind <= in_eoi ? KIND_RECORD_END : do_kind;
      idx      <= '0;
    end else if ((seq == SQ_DRAIN) && step_uq) begin
      idx <= idx_next;
    end
    if (step_uq && uq_res.emit) begin
      pend_ch <= uq_res.ch;
    end
    if (load_o) begin
      obuf_ch   <= o_ch;
      obuf_kind <= o_kind;
      obuf_last <= o_last;
      obuf_ovf  <= o_ovf;
    end
  end

  // no character is left pending once the sequencer is idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_IDLE) |-> !pend_v)
    else $error("pending character left when idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(HOLD_DEPTH))
    else $error("held whitespace count exceeds buffer depth");

  a_drain_index: assert property (@(posedge clk) disable iff (rst)
    (seq == SQ_DRAIN) |-> (idx < held_count))
    else $error("drain index past held whitespace");

  a_eoi_path: assert property (@(posedge clk) disable iff (rst)
    (accept && in_eoi) |=> ((seq == SQ_END) || (seq == SQ_EOS)))
    else $error("end of input did not start end sequence");

  a_field_end_clears: assert property (@(posedge clk) disable iff (rst)
    ((seq == SQ_END) && out_free) |=> ((held_count == '0) && !field_overflow))
    else $error("field end did not clear whitespace state");

endmodule
